// File: rtl/hashed_key_slot_lookup_assert.svh
// assertion macros for the hashed key slot lookup datapath
`ifndef HASHED_KEY_SLOT_LOOKUP_ASSERT_SVH
`define HASHED_KEY_SLOT_LOOKUP_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define HKSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hksl: same-cycle check failed");

// next-cycle implication, held off while reset is low
`define HKSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hksl: next-cycle check failed");

`endif

// File: rtl/hksl_pkg.sv
// shared constants and controller/datapath interface types for the slot lookup
`default_nettype none

package hksl_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned SLOT_W      = 10;
    localparam int unsigned MOD_CNT_W   = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - SLOT_W - HASH_W;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic mod_step;
        logic issue_rd;
        logic probe;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic hit;
        logic exhausted;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/hashed_key_slot_lookup.sv
// hashed key slot lookup: fnv-1a label hash with a linearly probed key table
// input stream carries one label byte per item, tlast on the final byte of a label.
// output stream gives one item per label: slot and hash in tdata, found/full flags in tuser.
// bytes are taken one per cycle while s_axis_tready is high; the hash multiply result is registered per byte.
// after the last byte the start index is found: with a power-of-two ENTRIES straight
// from the key, otherwise by a reciprocal multiply, a back multiply and a correcting
// subtract, each registered; probing follows, and the key memory gives one probe a cycle.
// the input takes no bytes from the last byte of a label until its result is loaded.
// a full table costs ENTRIES probes and returns slot 0 with the full flag set.
// after reset the key memory is zeroed one entry a cycle, every entry, with
// s_axis_tready low throughout; the hash starts again from the offset basis.
// a result waits in the output register while the receiver stalls; bytes of the next
// label are still taken, and its lookup holds its result until the register is free.
`default_nettype none

module hashed_key_slot_lookup #(
    parameter int unsigned ENTRIES = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [hksl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] label_byte
    input  wire logic                                 s_axis_tlast,  // last byte of label
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [hksl_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,  // [9:0] slot, [41:10] key_hash
    output logic [hksl_pkg::OUT_TUSER_W-1:0]          m_axis_tuser   // [0] found_existing, [1] table_full
);

    hksl_pkg::t_dp_cmd  w_cmd;
    hksl_pkg::t_dp_stat w_stat;

    logic [hksl_pkg::SLOT_W-1:0] w_slot;
    logic [hksl_pkg::HASH_W-1:0] w_hash;
    logic                        w_found;
    logic                        w_full;

    hksl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    hksl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_byte      (s_axis_tdata[hksl_pkg::BYTE_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_slot      (w_slot),
        .o_hash      (w_hash),
        .o_found     (w_found),
        .o_full      (w_full)
    );

    assign m_axis_tdata = {{hksl_pkg::OUT_PAD_W{1'b0}}, w_hash, w_slot};
    assign m_axis_tuser = {w_full, w_found};

endmodule

`default_nettype wire

// File: rtl/hksl_ctrl.sv
// sequencing state machine: clearing pass, byte intake, modulo, probing, result hand-off
`default_nettype none

module hksl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    input  wire hksl_pkg::t_dp_stat i_stat,
    output hksl_pkg::t_dp_cmd      o_cmd,
    output logic                   o_in_ready
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_MOD    = 6'b000100,
        S_ISSUE  = 6'b001000,
        S_CHECK  = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue_rd = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.probe = 1'b1;
                if (i_stat.hit || i_stat.exhausted) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // wait here only if the previous result has not been taken
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/hksl_dp.sv
// datapath: fnv-1a hash, start index reduction, key memory, probe counters, output register
`default_nettype none
`include "hashed_key_slot_lookup_assert.svh"

module hksl_dp #(
    parameter int unsigned ENTRIES = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire hksl_pkg::t_dp_cmd                i_cmd,
    output hksl_pkg::t_dp_stat                    o_stat,
    input  wire logic [hksl_pkg::BYTE_W-1:0]      i_byte,
    input  wire logic                             i_last,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [hksl_pkg::SLOT_W-1:0]           o_slot,
    output logic [hksl_pkg::HASH_W-1:0]           o_hash,
    output logic                                  o_found,
    output logic                                  o_full
);

    localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam bit          IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // hash accumulator and finished key
    logic [hksl_pkg::HASH_W-1:0] r_acc;
    logic [hksl_pkg::HASH_W-1:0] r_key;
    logic [hksl_pkg::HASH_W-1:0] w_mixed;
    logic [hksl_pkg::HASH_W-1:0] w_mul;

    assign w_mixed = r_acc ^ {{(hksl_pkg::HASH_W - hksl_pkg::BYTE_W){1'b0}}, i_byte};
    assign w_mul   = w_mixed * hksl_pkg::FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= hksl_pkg::FNV_BASIS;
        end else if (i_cmd.accept) begin
            r_acc <= i_last ? hksl_pkg::FNV_BASIS : w_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last) begin
            r_key <= w_mul;
        end
    end

    // start index: key modulo the entry count
    logic [IDX_W-1:0] w_start_idx;
    logic             w_mod_last;

    generate
        if (IS_POW2) begin : g_mod_mask
            assign w_start_idx = r_key[IDX_W-1:0];
            assign w_mod_last  = 1'b1;
        end else begin : g_mod_recip
            // reciprocal scaled so the quotient estimate is low by at most one
            localparam logic [63:0] RECIP_FULL = (64'd1 << (31 + IDX_W)) / 64'(ENTRIES);
            localparam logic [hksl_pkg::HASH_W-1:0] RECIP =
                RECIP_FULL[hksl_pkg::HASH_W-1:0];
            localparam logic [hksl_pkg::HASH_W-1:0] ENT_C = hksl_pkg::HASH_W'(ENTRIES);
            localparam logic [hksl_pkg::MOD_CNT_W-1:0] MOD_TOP = '1;

            logic [2*hksl_pkg::HASH_W-1:0]  r_prod;
            logic [hksl_pkg::HASH_W-1:0]    r_qe;
            logic [hksl_pkg::HASH_W-1:0]    r_diff;
            logic [hksl_pkg::HASH_W-1:0]    w_quot;
            logic [hksl_pkg::HASH_W-1:0]    w_fix;
            logic [hksl_pkg::MOD_CNT_W-1:0] r_mod_cnt;

            assign w_quot      = hksl_pkg::HASH_W'(r_prod >> (31 + IDX_W));
            assign w_fix       = r_diff - ENT_C;
            assign w_start_idx = (r_diff >= ENT_C) ? w_fix[IDX_W-1:0] : r_diff[IDX_W-1:0];
            assign w_mod_last  = (r_mod_cnt == MOD_TOP);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mod_cnt <= '0;
                end else if (i_cmd.accept) begin
                    r_mod_cnt <= '0;
                end else if (i_cmd.mod_step) begin
                    r_mod_cnt <= r_mod_cnt + 1'b1;
                end
            end

            // key times reciprocal, then quotient times entries, then key less that product
            always_ff @(posedge i_clk) begin
                if (i_cmd.mod_step) begin
                    r_prod <= {{hksl_pkg::HASH_W{1'b0}}, r_key} *
                              {{hksl_pkg::HASH_W{1'b0}}, RECIP};
                    r_qe   <= w_quot * ENT_C;
                    r_diff <= r_key - r_qe;
                end
            end
        end
    endgenerate

    // probe position and count
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              r_probes;
    logic [IDX_W-1:0]              w_idx_next;
    logic [hksl_pkg::HASH_W-1:0]   r_rdata;
    logic                          w_empty;
    logic                          w_match;
    logic                          w_hit;
    logic                          w_exhausted;
    logic                          w_advance;

    assign w_idx_next  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign w_empty     = (r_rdata == '0);
    assign w_match     = (r_rdata == r_key);
    assign w_hit       = w_empty || w_match;
    assign w_exhausted = (r_probes == LAST_IDX);
    assign w_advance   = i_cmd.probe && !w_hit && !w_exhausted;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_step && w_mod_last) begin
            r_idx    <= w_start_idx;
            r_probes <= '0;
        end else if (w_advance) begin
            r_idx    <= w_idx_next;
            r_probes <= r_probes + 1'b1;
        end
    end

    // clearing pass counter
    logic [IDX_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // key memory: one write and one registered read a cycle
    logic [hksl_pkg::HASH_W-1:0] r_mem [ENTRIES];
    logic                        w_wr_en;
    logic [IDX_W-1:0]            w_wr_addr;
    logic [hksl_pkg::HASH_W-1:0] w_wr_data;
    logic                        w_rd_en;
    logic [IDX_W-1:0]            w_rd_addr;

    assign w_wr_en   = i_cmd.clear_wr || (i_cmd.probe && w_hit);
    assign w_wr_addr = i_cmd.clear_wr ? r_clr_cnt : r_idx;
    assign w_wr_data = i_cmd.clear_wr ? '0 : r_key;
    assign w_rd_en   = i_cmd.issue_rd || w_advance;
    assign w_rd_addr = i_cmd.issue_rd ? r_idx : w_idx_next;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // lookup outcome held until the output register is free
    logic [IDX_W-1:0] r_res_idx;
    logic             r_res_found;
    logic             r_res_full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe) begin
            if (w_hit) begin
                r_res_idx   <= r_idx;
                r_res_found <= w_match && (r_key != '0);
                r_res_full  <= 1'b0;
            end else if (w_exhausted) begin
                r_res_idx   <= '0;
                r_res_found <= 1'b0;
                r_res_full  <= 1'b1;
            end
        end
    end

    // output register
    logic                          r_out_valid;
    logic [hksl_pkg::SLOT_W-1:0]   r_out_slot;
    logic [hksl_pkg::HASH_W-1:0]   r_out_hash;
    logic                          r_out_found;
    logic                          r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_slot  <= hksl_pkg::SLOT_W'(r_res_idx);
            r_out_hash  <= r_key;
            r_out_found <= r_res_found;
            r_out_full  <= r_res_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot      = r_out_slot;
    assign o_hash      = r_out_hash;
    assign o_found     = r_out_found;
    assign o_full      = r_out_full;

    assign o_stat.clear_last = (r_clr_cnt == LAST_IDX);
    assign o_stat.mod_last   = w_mod_last;
    assign o_stat.hit        = w_hit;
    assign o_stat.exhausted  = w_exhausted;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    `HKSL_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_cmd.load_out, !r_out_valid || i_out_ready)
    `HKSL_ASSERT_NEXT(a_acc_restart, i_clk, i_rst_n, i_cmd.accept && i_last, r_acc == hksl_pkg::FNV_BASIS)
    `HKSL_ASSERT_IMPL(a_full_shape, i_clk, i_rst_n, r_out_valid && r_out_full, r_out_slot == '0 && !r_out_found)
    `HKSL_ASSERT_IMPL(a_no_intake_in_clear, i_clk, i_rst_n, i_cmd.clear_wr, !i_cmd.accept && !i_cmd.probe)

endmodule

`default_nettype wire
